FILE: hdl/tcoa_pkg.sv
// Package for the three-channel oversample averager.
// Holds widths, constants, the request structs and the sequencer state type.
// Depends on nothing.
`default_nettype none

package tcoa_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int SUM_BITS      = 32;
  localparam int OSR_BITS      = 9;
  localparam int COUNT_BITS    = 8;
  localparam int AVG_BITS      = 24;
  localparam int BYTE_BITS     = 8;
  localparam int NUM_CH        = 3;
  localparam int CH_BITS       = 2;
  localparam int FRAME_BYTES   = 9;
  localparam int BYTE_CNT_BITS = 4;
  localparam int BIT_CNT_BITS  = $clog2(SUM_BITS);
  localparam int FRAME_BITS    = NUM_CH * AVG_BITS;
  localparam int OSR_RESET     = 16;
  localparam int OSR_CAP       = 256;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_first;
    logic [SAMPLE_BITS-1:0] sample_second;
    logic [SAMPLE_BITS-1:0] sample_third;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last_byte;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEND
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/three_channel_oversample_averager_unit.sv
// Top level of the three-channel oversample averager.
// Accumulates three converter codes per request and emits averaged frames as bytes.
// Depends on tcoa_pkg.
//
// Usage:
// The input channel (in_valid, in_stall, in_data) takes one request per
// data-ready event carrying three unsigned 24-bit codes. The first code feeds
// channel 1, the second channel 0 and the third channel 2.
// A request that does not complete a frame leaves the block idle and ready.
// When the event count reaches the ratio set on the configuration channel,
// the three sums are divided by the ratio in one shared bit-serial divider,
// one quotient bit per cycle, and then the first byte of the frame is
// offered on the output channel (out_valid, out_stall, out_data).
// Nine bytes follow, channel 0, 1 and 2, each most significant byte first,
// with last_byte set on the ninth.
// No new request is taken until the last byte of the frame has been taken.
// While the receiver stalls, the current byte is held and in_stall stays high.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) is always ready.
// Synchronous reset clears the sums and the count and sets the ratio to 16.
`default_nettype none

module three_channel_oversample_averager_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tcoa_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tcoa_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcoa_pkg::OSR_BITS-1:0] cfg_data
);
  import tcoa_pkg::*;

  state_t                   state, state_next;
  logic [OSR_BITS-1:0]      osr, osr_next;
  logic [SUM_BITS-1:0]      sums [NUM_CH];
  logic [SUM_BITS-1:0]      sums_next [NUM_CH];
  logic [COUNT_BITS-1:0]    count, count_next;
  logic [CH_BITS-1:0]       ch, ch_next;
  logic [BIT_CNT_BITS-1:0]  bit_cnt, bit_cnt_next;
  logic [BYTE_CNT_BITS-1:0] byte_cnt, byte_cnt_next;
  logic [OSR_BITS-1:0]      divisor, divisor_next;
  logic [SUM_BITS-1:0]      div_word, div_word_next;
  logic [OSR_BITS-1:0]      rem, rem_next;
  logic [FRAME_BITS-1:0]    frame, frame_next;

  logic [OSR_BITS-1:0]      ratio;
  logic [COUNT_BITS:0]      count_inc;
  logic [OSR_BITS:0]        trial;
  logic                     q_bit;
  logic [SUM_BITS-1:0]      word_shift;
  logic                     in_accept, out_accept;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign in_stall   = (state != ST_IDLE);
  assign out_valid  = (state == ST_SEND);
  assign cfg_ready  = 1'b1;
  assign out_data.out_byte  = frame[FRAME_BITS-1 -: BYTE_BITS];
  assign out_data.last_byte = (byte_cnt == BYTE_CNT_BITS'(FRAME_BYTES - 1));

  always_comb begin
    if (osr == '0) begin
      ratio = OSR_BITS'(1);
    end else if (osr > OSR_BITS'(OSR_CAP)) begin
      ratio = OSR_BITS'(OSR_CAP);
    end else begin
      ratio = osr;
    end
  end

  // One restoring division step: bring in the next dividend bit, try to subtract.
  always_comb begin
    trial = {rem, div_word[SUM_BITS-1]};
    q_bit = (trial >= {1'b0, divisor});
    word_shift = {div_word[SUM_BITS-2:0], q_bit};
  end

  assign count_inc = {1'b0, count} + (COUNT_BITS + 1)'(1);

  always_comb begin
    state_next    = state;
    osr_next      = osr;
    sums_next     = sums;
    count_next    = count;
    ch_next       = ch;
    bit_cnt_next  = bit_cnt;
    byte_cnt_next = byte_cnt;
    divisor_next  = divisor;
    div_word_next = div_word;
    rem_next      = rem;
    frame_next    = frame;

    if (cfg_valid && cfg_ready) begin
      osr_next = cfg_data;
    end

    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          sums_next[0] = sums[0] + SUM_BITS'(in_data.sample_second);
          sums_next[1] = sums[1] + SUM_BITS'(in_data.sample_first);
          sums_next[2] = sums[2] + SUM_BITS'(in_data.sample_third);
          if (count_inc >= ratio) begin
            count_next    = '0;
            divisor_next  = ratio;
            div_word_next = sums_next[0];
            rem_next      = '0;
            bit_cnt_next  = '0;
            ch_next       = '0;
            state_next    = ST_DIV;
          end else begin
            count_next = count_inc[COUNT_BITS-1:0];
          end
        end
      end
      ST_DIV: begin
        div_word_next = word_shift;
        if (q_bit) begin
          rem_next = OSR_BITS'(trial - {1'b0, divisor});
        end else begin
          rem_next = trial[OSR_BITS-1:0];
        end
        bit_cnt_next = bit_cnt + BIT_CNT_BITS'(1);
        if (bit_cnt == BIT_CNT_BITS'(SUM_BITS - 1)) begin
          frame_next   = {frame[FRAME_BITS-AVG_BITS-1:0], word_shift[AVG_BITS-1:0]};
          bit_cnt_next = '0;
          rem_next     = '0;
          if (ch == CH_BITS'(NUM_CH - 1)) begin
            for (int i = 0; i < NUM_CH; i++) begin
              sums_next[i] = '0;
            end
            byte_cnt_next = '0;
            state_next    = ST_SEND;
          end else begin
            ch_next       = ch + CH_BITS'(1);
            div_word_next = sums[ch_next];
          end
        end
      end
      ST_SEND: begin
        if (out_accept) begin
          frame_next    = {frame[FRAME_BITS-BYTE_BITS-1:0], BYTE_BITS'(0)};
          byte_cnt_next = byte_cnt + BYTE_CNT_BITS'(1);
          if (out_data.last_byte) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      osr      <= OSR_BITS'(OSR_RESET);
      count    <= '0;
      ch       <= '0;
      bit_cnt  <= '0;
      byte_cnt <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        sums[i] <= '0;
      end
    end else begin
      osr      <= osr_next;
      count    <= count_next;
      ch       <= ch_next;
      bit_cnt  <= bit_cnt_next;
      byte_cnt <= byte_cnt_next;
      sums     <= sums_next;
    end
  end

  always_ff @(posedge clk) begin
    divisor  <= divisor_next;
    div_word <= div_word_next;
    rem      <= rem_next;
    frame    <= frame_next;
  end

endmodule

`default_nettype wire

FILE: hdl/tcoa_checker.sv
// Port-level checker for the three-channel oversample averager.
// Bound to three_channel_oversample_averager_unit; depends on tcoa_pkg.
`default_nettype none

module tcoa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input tcoa_pkg::out_item_t           out_data
);

  // No new request is taken while a frame is being sent.
  a_stall_while_sending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a frame is pending");

  // A request either leaves the block idle or starts the division, so no byte appears right after it.
  a_no_immediate_byte: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("output byte right after an input request");

  // After the ninth byte is taken the frame is over.
  a_frame_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.last_byte) |=> !out_valid)
    else $error("output still valid after the last byte");

  // A stalled byte stays offered and unchanged.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output request changed");

endmodule

bind three_channel_oversample_averager_unit tcoa_checker u_tcoa_checker (.*);

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for three_channel_oversample_averager_unit.
// Drives converter events, predicts the averaged byte frames, and checks every byte.
// Depends on tcoa_pkg and the averager RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcoa_pkg::*;

  localparam int ITEM_TARGET   = 450;
  localparam int SETTLE_CYCLES = 120;
  localparam int IDLE_LIMIT    = 5000;
  localparam int PRESSURE_HOLD = 600;
  localparam logic [SAMPLE_BITS-1:0] CODE_MAX = '1;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [OSR_BITS-1:0] cfg_data  = '0;

  logic [OSR_BITS-1:0]   ratio_reg = OSR_BITS'(OSR_RESET);
  logic [SUM_BITS-1:0]   chan_sum [NUM_CH];
  logic [COUNT_BITS-1:0] event_count;
  out_item_t             expected_bytes [$];
  in_item_t              pending_events [$];

  int items_queued    = 0;
  int events_accepted = 0;
  int mismatches      = 0;
  int frames_done     = 0;
  int idle_cycles     = 0;
  int burst_left      = 0;
  int gap_left        = 0;
  int hold_left       = 0;
  int pressure_left   = 0;
  int segment_left    = 0;
  int stall_mode      = 0;
  bit pressure_done   = 1'b0;

  three_channel_oversample_averager_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [OSR_BITS-1:0] active_ratio(input logic [OSR_BITS-1:0] raw);
    if (raw == '0) begin
      return OSR_BITS'(1);
    end
    if (raw > OSR_BITS'(OSR_CAP)) begin
      return OSR_BITS'(OSR_CAP);
    end
    return raw;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_code(input bit favor_max);
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) begin
      return '0;
    end
    if (roll == 1 || (favor_max && roll < 5)) begin
      return CODE_MAX;
    end
    return SAMPLE_BITS'($urandom);
  endfunction

  // The first code feeds channel 1 and the second feeds channel 0.
  task automatic accumulate_event(input in_item_t req);
    logic [OSR_BITS-1:0] ratio;
    logic [OSR_BITS-1:0] next_count;
    logic [SUM_BITS-1:0] avg;
    out_item_t           b;
    ratio = active_ratio(ratio_reg);
    chan_sum[1] = chan_sum[1] + SUM_BITS'(req.sample_first);
    chan_sum[0] = chan_sum[0] + SUM_BITS'(req.sample_second);
    chan_sum[2] = chan_sum[2] + SUM_BITS'(req.sample_third);
    next_count = OSR_BITS'(event_count) + 1'b1;
    if (next_count < ratio) begin
      event_count = next_count[COUNT_BITS-1:0];
    end else begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        avg = chan_sum[ch] / SUM_BITS'(ratio);
        for (int k = 2; k >= 0; k--) begin
          b.out_byte  = avg[k*BYTE_BITS +: BYTE_BITS];
          b.last_byte = (ch == NUM_CH - 1) && (k == 0);
          expected_bytes.push_back(b);
        end
      end
      event_count = '0;
      chan_sum    = '{default: '0};
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at %0t ns: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic queue_event(input logic [SAMPLE_BITS-1:0] first,
                             input logic [SAMPLE_BITS-1:0] second,
                             input logic [SAMPLE_BITS-1:0] third);
    in_item_t req;
    req.sample_first  = first;
    req.sample_second = second;
    req.sample_third  = third;
    pending_events.push_back(req);
    items_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (events_accepted != items_queued || expected_bytes.size() != 0);
  endtask

  // An event that closes no frame leaves no trace on the output, so the block
  // gets a full frame time to settle before the ratio changes.
  task automatic write_ratio(input logic [OSR_BITS-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    ratio_reg = value;
  endtask

  initial begin : stimulus
    logic [OSR_BITS-1:0] ratio;
    int                  frames;
    int                  n;
    chan_sum    = '{default: '0};
    event_count = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    repeat (16) queue_event(CODE_MAX, CODE_MAX, CODE_MAX);
    write_ratio('0);
    queue_event('0, '0, '0);
    queue_event(CODE_MAX, CODE_MAX, CODE_MAX);
    queue_event(24'h123456, 24'hABCDEF, 24'h00FF00);
    queue_event(CODE_MAX, '0, 24'h800001);
    // Lowering the ratio mid-frame closes the frame on the next event, so the
    // average of three events divided by one overflows the 24-bit field.
    write_ratio(OSR_BITS'(3));
    repeat (2) queue_event(CODE_MAX, pick_code(1'b0), CODE_MAX);
    write_ratio(OSR_BITS'(1));
    queue_event(CODE_MAX, pick_code(1'b0), pick_code(1'b0));

    write_ratio(OSR_BITS'(2));
    repeat (40) queue_event(pick_code(1'b0), pick_code(1'b0), pick_code(1'b0));
    write_ratio(OSR_BITS'(OSR_CAP));
    repeat (OSR_CAP) queue_event(pick_code(1'b1), pick_code(1'b1), pick_code(1'b1));
    write_ratio('1);
    repeat ($urandom_range(3, 12)) queue_event(pick_code(1'b0), pick_code(1'b0), pick_code(1'b0));

    while (items_queued < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       ratio = '0;
        1:       ratio = OSR_BITS'($urandom_range(9, 40));
        2:       ratio = OSR_BITS'($urandom_range(OSR_CAP + 1, 511));
        default: ratio = OSR_BITS'($urandom_range(1, 8));
      endcase
      if (ratio > OSR_BITS'(OSR_CAP)) begin
        n = $urandom_range(2, 12);
      end else begin
        frames = (ratio > 8) ? 1 : $urandom_range(1, 4);
        n = int'(active_ratio(ratio)) * frames + $urandom_range(0, 2);
      end
      write_ratio(ratio);
      repeat (n) queue_event(pick_code(1'b0), pick_code(1'b0), pick_code(1'b0));
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin : request_driver
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        accumulate_event(in_data);
        events_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || pending_events.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0) begin
            gap_left--;
          end
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_events.pop_front();
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
  end

  // One long hold-off while events are still queued fills the block up.
  always @(posedge clk) begin : pressure_hold
    if (rst) begin
      pressure_left <= 0;
    end else if (!pressure_done && frames_done >= 8 && pending_events.size() > 10) begin
      pressure_left <= PRESSURE_HOLD;
      pressure_done <= 1'b1;
    end else if (pressure_left != 0) begin
      pressure_left <= pressure_left - 1;
    end
  end

  always @(posedge clk) begin : byte_monitor
    out_item_t want;
    bit        stall_now;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_data.out_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("byte %02h, expected %02h",
                                      out_data.out_byte, want.out_byte));
          end
          if (out_data.last_byte !== want.last_byte) begin
            report_mismatch($sformatf("last flag %b, expected %b",
                                      out_data.last_byte, want.last_byte));
          end
        end
        if (out_data.last_byte === 1'b1) begin
          frames_done++;
        end
      end

      if (segment_left == 0) begin
        stall_mode   = $urandom_range(0, 3);
        segment_left = $urandom_range(20, 200);
      end else begin
        segment_left--;
      end
      if (hold_left == 0) begin
        case (stall_mode)
          0: stall_now = 1'b0;
          1: stall_now = ($urandom_range(0, 3) == 0);
          2: stall_now = ($urandom_range(0, 3) != 0);
          default: begin
            stall_now = 1'b0;
            if ($urandom_range(0, 15) == 0) begin
              hold_left = $urandom_range(5, 40);
            end
          end
        endcase
      end
      if (hold_left != 0) begin
        stall_now = 1'b1;
        hold_left--;
      end
      if (pressure_left != 0) begin
        stall_now = 1'b1;
      end
      out_stall <= stall_now;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: files.f
hdl/tcoa_pkg.sv
hdl/three_channel_oversample_averager_unit.sv
hdl/tcoa_checker.sv
sim/tb.sv
